>>> design/apsc_pkg.sv
// Package for the Annex-B parameter-set capture block.
// Holds the shared constants, parser state types and result item type.
// Used by every module of the block but apsc_ram; it depends on nothing else.
package apsc_pkg;

   // Longest parameter set that is captured, in bytes.
   localparam int MAX_SET_BYTES = 128;

   localparam int LEN_W   = 8;
   localparam int TYPE_W  = 5;
   localparam int CNT_W   = $clog2(MAX_SET_BYTES + 2);
   localparam int SLOT_AW = ($clog2(MAX_SET_BYTES) > 7) ? $clog2(MAX_SET_BYTES) : 7;
   localparam int RAM_AW  = SLOT_AW + 1;
   localparam int RAM_DEPTH = 2 ** RAM_AW;

   localparam int QUEUE_DEPTH = 3;
   localparam int Q_AW = $clog2(QUEUE_DEPTH);
   localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TYPE_W-1:0] TYPE_MASK = 5'h1F;
   localparam logic [TYPE_W-1:0] NAL_SPS   = 5'd7;
   localparam logic [TYPE_W-1:0] NAL_PPS   = 5'd8;

   localparam logic REQ_STREAM = 1'b0;
   localparam logic REQ_READ   = 1'b1;
   localparam logic SEL_SPS    = 1'b0;
   localparam logic SEL_PPS    = 1'b1;

   // Bytes pending from a position to the frame end, as seen in mid-frame.
   localparam logic [2:0] AVAIL_FULL  = 3'd5;
   localparam logic [2:0] AVAIL_CODE  = 3'd4;
   localparam logic [2:0] WINDOW_FULL = 3'd4;

   typedef enum logic [4:0] {
      PH_SEARCH = 5'b00001,
      PH_BODY   = 5'b00010,
      PH_SKIP1  = 5'b00100,
      PH_SKIP2  = 5'b01000,
      PH_SKIP3  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      OP_SCAN  = 2'b01,
      OP_CLOSE = 2'b10
   } scan_op_type;

   typedef enum logic [2:0] {
      ST_RUN    = 3'b001,
      ST_FLUSH  = 3'b010,
      ST_FINISH = 3'b100
   } ctl_state_type;

   typedef struct packed {
      phase_type         phase;
      logic [TYPE_W-1:0] unit_type;
      logic [CNT_W-1:0]  unit_count;
      logic              sps_sel;
      logic              pps_sel;
      logic [LEN_W-1:0]  sps_len;
      logic [LEN_W-1:0]  pps_len;
      logic [1:0]        seen;
   } parse_state_type;

   typedef struct packed {
      logic              sps_we;
      logic              pps_we;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        data;
   } store_write_type;

   typedef struct packed {
      logic [LEN_W-1:0] pps_length;
      logic [LEN_W-1:0] sps_length;
      logic             cache_valid;
      logic [7:0]       read_data;
   } rsp_item_type;

endpackage

>>> design/apsc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; no package needed.
module apsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> design/apsc_scan.sv
// Start-code scanner: advances the parser by one stream position, or closes
// the frame. Purely combinational; uses apsc_pkg.
module apsc_scan (
   input  apsc_pkg::parse_state_type cur,
   input  logic [31:0]               window,
   input  logic [2:0]                avail,
   input  apsc_pkg::scan_op_type     op,
   output apsc_pkg::parse_state_type nxt,
   output apsc_pkg::store_write_type wr,
   output logic                      both_seen
);
   import apsc_pkg::*;

   typedef enum logic [1:0] {
      CODE_NONE = 2'd0,
      CODE_3    = 2'd1,
      CODE_4    = 2'd2
   } code_type;

   code_type          code;
   logic [TYPE_W-1:0] type_eff;
   logic              fin;
   logic              slot;

   // Oldest byte sits in bits 7:0 of the window.
   always_comb begin
      if (window[7:0] == 8'h00 && window[15:8] == 8'h00 && window[23:16] == 8'h01) begin
         code = CODE_3;
      end else if (window[7:0] == 8'h00 && window[15:8] == 8'h00 &&
                   window[23:16] == 8'h00 && window[31:24] == 8'h01) begin
         code = CODE_4;
      end else begin
         code = CODE_NONE;
      end
   end

   always_comb begin
      nxt       = cur;
      type_eff  = cur.unit_type;
      fin       = 1'b0;
      both_seen = 1'b0;
      wr.sps_we = 1'b0;
      wr.pps_we = 1'b0;
      wr.data   = window[7:0];
      slot      = 1'b0;

      case (op)
         OP_SCAN: begin
            case (cur.phase)
               PH_SEARCH: begin
                  if (avail >= AVAIL_FULL) begin
                     if (code == CODE_3) begin
                        nxt.phase = PH_SKIP2;
                     end else if (code == CODE_4) begin
                        nxt.phase = PH_SKIP3;
                     end
                  end
               end
               PH_SKIP3: nxt.phase = PH_SKIP2;
               PH_SKIP2: nxt.phase = PH_SKIP1;
               PH_SKIP1: nxt.phase = PH_BODY;
               PH_BODY: begin
                  // The first body byte carries the unit header.
                  if (cur.unit_count == '0) begin
                     type_eff = window[TYPE_W-1:0] & TYPE_MASK;
                  end
                  nxt.unit_type = type_eff;
                  if (avail >= AVAIL_CODE && code != CODE_NONE) begin
                     fin = 1'b1;
                     if (avail >= AVAIL_FULL) begin
                        nxt.phase = (code == CODE_3) ? PH_SKIP2 : PH_SKIP3;
                     end else begin
                        nxt.phase = PH_SEARCH;
                     end
                  end else begin
                     if (cur.unit_count < CNT_W'(MAX_SET_BYTES)) begin
                        wr.sps_we = (type_eff == NAL_SPS);
                        wr.pps_we = (type_eff == NAL_PPS);
                     end
                     if (cur.unit_count <= CNT_W'(MAX_SET_BYTES)) begin
                        nxt.unit_count = cur.unit_count + CNT_W'(1);
                     end
                  end
               end
               default: ;
            endcase
         end
         OP_CLOSE: fin = (cur.phase == PH_BODY);
         default: ;
      endcase

      // Writes go to the slot that is not being read.
      slot    = (type_eff == NAL_SPS) ? ~cur.sps_sel : ~cur.pps_sel;
      wr.addr = {slot, SLOT_AW'(cur.unit_count)};

      if (fin) begin
         if (cur.unit_count <= CNT_W'(MAX_SET_BYTES)) begin
            if (type_eff == NAL_SPS) begin
               nxt.sps_sel = ~cur.sps_sel;
               nxt.sps_len = LEN_W'(cur.unit_count);
               nxt.seen[0] = 1'b1;
            end else if (type_eff == NAL_PPS) begin
               nxt.pps_sel = ~cur.pps_sel;
               nxt.pps_len = LEN_W'(cur.unit_count);
               nxt.seen[1] = 1'b1;
            end
         end
         nxt.unit_count = '0;
      end

      if (op == OP_CLOSE) begin
         both_seen      = &nxt.seen;
         nxt.seen       = '0;
         nxt.phase      = PH_SEARCH;
         nxt.unit_type  = '0;
         nxt.unit_count = '0;
      end
   end
endmodule

>>> design/apsc_rsp_queue.sv
// Three-entry result queue between the read pipeline and the result channel.
// Uses apsc_pkg for the result item type.
module apsc_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  apsc_pkg::rsp_item_type   push_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output apsc_pkg::rsp_item_type   out_item,
   output logic [apsc_pkg::Q_CW-1:0] count
);
   import apsc_pkg::*;

   rsp_item_type    mem_ff [QUEUE_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] count_ff, count_in;
   logic            pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + Q_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == Q_CW'(QUEUE_DEPTH)))
      else $error("result queue pushed while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CW'(QUEUE_DEPTH))
      else $error("result queue count out of range");

   // A waiting head item holds still until it is taken.
   a_head_stable: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
      else $error("result queue head changed while waiting");
`endif
endmodule

>>> design/annexb_parameter_set_capture_top.sv
// Top level of the Annex-B parameter-set capture block.
// Instantiates apsc_scan, apsc_ram (two stores) and apsc_rsp_queue; uses apsc_pkg.
//
// The block takes H.264 Annex-B stream bytes and read requests as items on the
// req_ channel. Stream items carry one frame byte each, with req_tlast on the
// final byte of the frame. The parser finds 3- and 4-byte start codes through a
// four-byte window and splits each frame into NAL units; SPS (type 7) and PPS
// (type 8) units no longer than MAX_SET_BYTES are written into a double-buffered
// store, and the slot flips only when a unit is complete, so a read always sees
// the last completed unit. Once one frame has yielded both an SPS and a PPS the
// cache is marked valid and later frames are passed over. A read item returns one
// byte of the selected store; every final stream byte returns a status item with
// read_data zero. Each result is registered in the read pipeline stage and then
// queued. Reads and non-final stream bytes are taken one per cycle while the
// result queue has room. The final byte of a frame that is still being parsed
// holds the input while the single scan unit drains the up to four bytes left
// in the window, one position per cycle because each may write one store byte,
// and then closes the frame and posts its status once the queue has room.
// Frames seen after the cache is valid cost nothing extra. Store bytes that were
// never written read as undefined; the stores need no clearing after reset.
module annexb_parameter_set_capture_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [8] read_select, [15:9] read_index
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   // [0] req_type
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] cache_valid, [16:9] sps_length, [24:17] pps_length,
   // [31:25] zero
   output logic [31:0] rsp_tdata
);
   import apsc_pkg::*;

   // Request fields.
   logic [7:0] data_byte;
   logic       read_select;
   logic [6:0] read_index;
   logic       is_read;

   assign data_byte   = req_tdata[7:0];
   assign read_select = req_tdata[8];
   assign read_index  = req_tdata[15:9];
   assign is_read     = (req_tuser[0] == REQ_READ);

   // Control and parser state.
   ctl_state_type   state_ff, state_in;
   parse_state_type pst_ff, pst_in;
   logic [31:0]     window_ff, window_in;
   logic [2:0]      fill_ff, fill_in;
   logic            valid_ff, valid_in;

   // Read pipeline stage that lines up with the store read latency.
   logic             p_valid_ff, p_valid_in;
   logic             p_read_ff, p_read_in;
   logic             p_sel_ff, p_sel_in;
   logic             p_cache_ff, p_cache_in;
   logic [LEN_W-1:0] p_sps_len_ff, p_sps_len_in;
   logic [LEN_W-1:0] p_pps_len_ff, p_pps_len_in;

   // Scanner hookup.
   parse_state_type scan_nxt;
   store_write_type scan_wr;
   logic            scan_both;
   logic [2:0]      scan_avail;
   scan_op_type     scan_op;
   logic            scan_apply;

   logic            accept;
   logic            space;
   logic [Q_CW-1:0] q_count;
   logic [7:0]      sps_rd_data, pps_rd_data;
   rsp_item_type    p_item, head_item;
   logic            sps_we, pps_we;

   // A new result may enter only if the queue can still hold it and the one in
   // flight.
   assign space      = ((Q_CW + 1)'(q_count) + (Q_CW + 1)'(p_valid_ff)) <
                       (Q_CW + 1)'(QUEUE_DEPTH);
   assign req_tready = (state_ff == ST_RUN) && space;
   assign accept     = req_tvalid && req_tready;

   assign scan_avail = (state_ff == ST_FLUSH) ? fill_ff : AVAIL_FULL;
   assign scan_op    = (state_ff == ST_FINISH) ? OP_CLOSE : OP_SCAN;

   apsc_scan u_scan (
      .cur       (pst_ff),
      .window    (window_ff),
      .avail     (scan_avail),
      .op        (scan_op),
      .nxt       (scan_nxt),
      .wr        (scan_wr),
      .both_seen (scan_both)
   );

   always_comb begin
      state_in     = state_ff;
      pst_in       = pst_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      valid_in     = valid_ff;
      scan_apply   = 1'b0;
      p_valid_in   = 1'b0;
      p_read_in    = 1'b0;
      p_sel_in     = p_sel_ff;
      p_cache_in   = valid_ff;
      p_sps_len_in = pst_ff.sps_len;
      p_pps_len_in = pst_ff.pps_len;

      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (is_read) begin
                  p_valid_in = 1'b1;
                  p_read_in  = 1'b1;
                  p_sel_in   = read_select;
               end else if (valid_ff) begin
                  // Cache is locked: the frame is passed over, only its end reports.
                  p_valid_in = req_tlast;
               end else begin
                  if (fill_ff == WINDOW_FULL) begin
                     scan_apply = 1'b1;
                     pst_in     = scan_nxt;
                     window_in  = {data_byte, window_ff[31:8]};
                  end else begin
                     window_in = window_ff | (32'(data_byte) << {fill_ff[1:0], 3'b000});
                     fill_in   = fill_ff + 3'd1;
                  end
                  if (req_tlast) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            // Drain the window with the true distance to the frame end.
            scan_apply = 1'b1;
            pst_in     = scan_nxt;
            window_in  = {8'h00, window_ff[31:8]};
            fill_in    = fill_ff - 3'd1;
            if (fill_ff == 3'd1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (space) begin
               pst_in       = scan_nxt;
               valid_in     = scan_both;
               window_in    = '0;
               fill_in      = '0;
               p_valid_in   = 1'b1;
               p_cache_in   = scan_both;
               p_sps_len_in = scan_nxt.sps_len;
               p_pps_len_in = scan_nxt.pps_len;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_RUN;
         pst_ff.phase       <= PH_SEARCH;
         pst_ff.unit_type   <= '0;
         pst_ff.unit_count  <= '0;
         pst_ff.sps_sel     <= 1'b0;
         pst_ff.pps_sel     <= 1'b0;
         pst_ff.sps_len     <= '0;
         pst_ff.pps_len     <= '0;
         pst_ff.seen        <= '0;
         window_ff          <= '0;
         fill_ff            <= '0;
         valid_ff           <= 1'b0;
         p_valid_ff         <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pst_ff     <= pst_in;
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         valid_ff   <= valid_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_read_ff    <= p_read_in;
      p_sel_ff     <= p_sel_in;
      p_cache_ff   <= p_cache_in;
      p_sps_len_ff <= p_sps_len_in;
      p_pps_len_ff <= p_pps_len_in;
   end

   assign sps_we = scan_apply && scan_wr.sps_we;
   assign pps_we = scan_apply && scan_wr.pps_we;

   // Each store holds two slots; the active slot is read, the other is filled.
   apsc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_sps_ram (
      .clock   (clock),
      .wr_en   (sps_we),
      .wr_addr (scan_wr.addr),
      .wr_data (scan_wr.data),
      .rd_en   (accept && is_read && read_select == SEL_SPS),
      .rd_addr ({pst_ff.sps_sel, SLOT_AW'(read_index)}),
      .rd_data (sps_rd_data)
   );

   apsc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_pps_ram (
      .clock   (clock),
      .wr_en   (pps_we),
      .wr_addr (scan_wr.addr),
      .wr_data (scan_wr.data),
      .rd_en   (accept && is_read && read_select == SEL_PPS),
      .rd_addr ({pst_ff.pps_sel, SLOT_AW'(read_index)}),
      .rd_data (pps_rd_data)
   );

   always_comb begin
      p_item.read_data   = '0;
      if (p_read_ff) begin
         p_item.read_data = (p_sel_ff == SEL_PPS) ? pps_rd_data : sps_rd_data;
      end
      p_item.cache_valid = p_cache_ff;
      p_item.sps_length  = p_sps_len_ff;
      p_item.pps_length  = p_pps_len_ff;
   end

   apsc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (p_valid_ff),
      .push_item (p_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head_item),
      .count     (q_count)
   );

   assign rsp_tdata = {7'b0000000, head_item.pps_length, head_item.sps_length,
                       head_item.cache_valid, head_item.read_data};

`ifndef SYNTHESIS
   // A unit under capture must never land in the slot that reads are served from.
   a_sps_inactive_slot: assert property (@(posedge clock) disable iff (reset)
      sps_we |-> (scan_wr.addr[RAM_AW-1] != pst_ff.sps_sel))
      else $error("SPS write hit the active slot");

   a_pps_inactive_slot: assert property (@(posedge clock) disable iff (reset)
      pps_we |-> (scan_wr.addr[RAM_AW-1] != pst_ff.pps_sel))
      else $error("PPS write hit the active slot");

   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> valid_ff)
      else $error("cache valid flag dropped");

   a_flush_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (fill_ff != 3'd0 && fill_ff <= WINDOW_FULL))
      else $error("window drain with no pending byte");
`endif
endmodule
